[rtl/core/bgc_pkg.sv]
// bgc_pkg: shared types and constants of the bipartite graph checker.
// Used by every module under rtl/core but bgc_ram; depends on nothing.
`default_nettype none

package bgc_pkg;

    // Fixed field widths of the stream and configuration ports, and of a node color
    localparam int NODE_IN_W = 10;
    localparam int CFG_W     = 11;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;
    localparam int HUE_W     = 2;

    // Node color codes held in the node memory
    typedef enum logic [HUE_W-1:0] {
        HUE_NONE = 2'd0,
        HUE_ZERO = 2'd1,
        HUE_ONE  = 2'd2
    } hue_t;

    // Load bookkeeping status seen by the walk controller
    typedef struct packed {
        logic error;
        logic has_entries;
    } load_flags_t;

    // One result
    typedef struct packed {
        logic input_error;
        logic bipartite;
    } result_t;

    // Color given to an uncolored neighbor
    function automatic hue_t hue_flip(input hue_t h);
        hue_t r;
        unique case (h)
            HUE_ZERO: r = HUE_ONE;
            HUE_ONE:  r = HUE_ZERO;
            default:  r = HUE_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/graph_bipartite_check_top.sv]
// Bipartite check of one graph: loads adjacency entries, one per cycle while tready is high.
// After the entry marked tlast it decides (an input error or an empty graph ends it there), then
// scans seed nodes (node read, check), walks stored entries (list read, node read, check) and
// pops nodes (stack read, node read), paced by the registered memory reads. The result is held
// in the output register and, for a graph with entries, node memory 0 to highest is cleared.
// Reset (rst_n low, asynchronous) clears control and then all MAX_NODES nodes, with tready low.
// Depends on bgc_pkg, bgc_ram, bgc_loader and bgc_walker.
`default_nettype none

module graph_bipartite_check_top
    import bgc_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_ENTRIES = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration: node_count
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // entries
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [9:0] owner_node, [19:10] neighbor_node
    input  wire logic                 s_axis_tuser,   // [0] is_entry
    input  wire logic                 s_axis_tlast,   // last
    // results
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,   // [0] bipartite
    output logic                      m_axis_tuser    // [0] input_error
);

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int NODE_CW = $clog2(MAX_NODES + 1);
    localparam int ENT_AW  = $clog2(MAX_ENTRIES);
    localparam int ENT_CW  = $clog2(MAX_ENTRIES + 1);
    localparam int N_W     = (NODE_CW > CFG_W) ? NODE_CW : CFG_W;
    localparam int NODE_DW = HUE_W + ENT_AW + ENT_CW;

    logic [CFG_W-1:0] node_count_reg;
    logic [N_W-1:0]   count_ext, active_nodes;
    logic             in_accept, last_accept, out_free;
    logic             out_valid_reg;
    result_t          out_res_reg;

    load_flags_t        flags;
    logic [NODE_AW-1:0] highest;
    logic               graph_clear, res_valid;
    result_t            res;

    logic               ld_node_we, node_we, node_re;
    logic [NODE_AW-1:0] ld_node_waddr, node_waddr, node_raddr;
    logic [NODE_DW-1:0] ld_node_wdata, node_wdata, node_rdata;
    logic               list_we, list_re;
    logic [ENT_AW-1:0]  list_waddr, list_raddr;
    logic [NODE_AW-1:0] list_wdata, list_rdata;
    logic               stk_we, stk_re;
    logic [NODE_AW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // Node count limited to the memory depth
    assign count_ext    = N_W'(node_count_reg);
    assign active_nodes = (count_ext > N_W'(MAX_NODES)) ? N_W'(MAX_NODES) : count_ext;

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign last_accept = in_accept && s_axis_tlast;
    assign out_free    = !out_valid_reg || m_axis_tready;

    bgc_loader #(
        .MAX_NODES   (MAX_NODES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_loader (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_accept),
        .is_entry      (s_axis_tuser),
        .owner_node    (s_axis_tdata[NODE_IN_W-1:0]),
        .neighbor_node (s_axis_tdata[2*NODE_IN_W-1:NODE_IN_W]),
        .active_nodes  (active_nodes),
        .graph_clear   (graph_clear),
        .node_we       (ld_node_we),
        .node_waddr    (ld_node_waddr),
        .node_wdata    (ld_node_wdata),
        .list_we       (list_we),
        .list_waddr    (list_waddr),
        .list_wdata    (list_wdata),
        .flags         (flags),
        .highest       (highest)
    );

    bgc_walker #(
        .MAX_NODES   (MAX_NODES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .last_accept   (last_accept),
        .active_nodes  (active_nodes),
        .flags         (flags),
        .highest       (highest),
        .out_free      (out_free),
        .ld_node_we    (ld_node_we),
        .ld_node_waddr (ld_node_waddr),
        .ld_node_wdata (ld_node_wdata),
        .node_we       (node_we),
        .node_waddr    (node_waddr),
        .node_wdata    (node_wdata),
        .node_re       (node_re),
        .node_raddr    (node_raddr),
        .node_rdata    (node_rdata),
        .list_re       (list_re),
        .list_raddr    (list_raddr),
        .list_rdata    (list_rdata),
        .stk_we        (stk_we),
        .stk_waddr     (stk_waddr),
        .stk_wdata     (stk_wdata),
        .stk_re        (stk_re),
        .stk_raddr     (stk_raddr),
        .stk_rdata     (stk_rdata),
        .in_ready      (s_axis_tready),
        .res_valid     (res_valid),
        .res           (res),
        .graph_clear   (graph_clear)
    );

    // Node memory: {color, list start, list length}
    bgc_ram #(
        .WIDTH (NODE_DW),
        .DEPTH (MAX_NODES)
    ) u_node_mem (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Neighbor store, packed in arrival order
    bgc_ram #(
        .WIDTH (NODE_AW),
        .DEPTH (MAX_ENTRIES)
    ) u_list_mem (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .re    (list_re),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    // Walk stack
    bgc_ram #(
        .WIDTH (NODE_AW),
        .DEPTH (MAX_NODES)
    ) u_stack_mem (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_res_reg.bipartite);
    assign m_axis_tuser  = out_res_reg.input_error;

endmodule

`default_nettype wire

[rtl/core/bgc_ram.sv]
// bgc_ram: simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module bgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/bgc_loader.sv]
// bgc_loader: checks incoming adjacency entries and builds the compressed lists.
// Depends on bgc_pkg; writes the node memory (via bgc_walker) and the neighbor store.
`default_nettype none

module bgc_loader
    import bgc_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_ENTRIES = 4096,
    localparam int NODE_AW = $clog2(MAX_NODES),
    localparam int NODE_CW = $clog2(MAX_NODES + 1),
    localparam int ENT_AW  = $clog2(MAX_ENTRIES),
    localparam int ENT_CW  = $clog2(MAX_ENTRIES + 1),
    localparam int N_W     = (NODE_CW > CFG_W) ? NODE_CW : CFG_W,
    localparam int NODE_DW = HUE_W + ENT_AW + ENT_CW
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_accept,
    input  wire logic                 is_entry,
    input  wire logic [NODE_IN_W-1:0] owner_node,
    input  wire logic [NODE_IN_W-1:0] neighbor_node,
    input  wire logic [N_W-1:0]       active_nodes,
    input  wire logic                 graph_clear,
    output logic                      node_we,
    output logic      [NODE_AW-1:0]   node_waddr,
    output logic      [NODE_DW-1:0]   node_wdata,
    output logic                      list_we,
    output logic      [ENT_AW-1:0]    list_waddr,
    output logic      [NODE_AW-1:0]   list_wdata,
    output load_flags_t               flags,
    output logic      [NODE_AW-1:0]   highest
);

    logic [ENT_CW-1:0]    entry_count_reg, entry_count_next;
    logic                 owner_seen_reg, owner_seen_next;
    logic [NODE_IN_W-1:0] prev_owner_reg, prev_owner_next;
    logic                 error_reg, error_next;
    logic [NODE_AW-1:0]   highest_reg, highest_next;
    logic [ENT_AW-1:0]    start_reg, start_next;
    logic [ENT_CW-1:0]    len_reg, len_next;

    logic [N_W-1:0]     owner_ext, nb_ext;
    logic [NODE_AW-1:0] owner_a, nb_a, hi_tmp;
    logic               out_of_range, order_bad, store_full, take, new_owner;
    logic [ENT_AW-1:0]  start_use;
    logic [ENT_CW-1:0]  len_use;

    // Entry checks and list bookkeeping
    always_comb
    begin
        owner_ext    = N_W'(owner_node);
        nb_ext       = N_W'(neighbor_node);
        owner_a      = owner_ext[NODE_AW-1:0];
        nb_a         = nb_ext[NODE_AW-1:0];
        out_of_range = (owner_ext >= active_nodes) || (nb_ext >= active_nodes);
        order_bad    = owner_seen_reg && (owner_node < prev_owner_reg);
        store_full   = (entry_count_reg == ENT_CW'(MAX_ENTRIES));
        take         = in_accept && is_entry && !out_of_range && !order_bad && !store_full;
        new_owner    = !owner_seen_reg || (owner_node != prev_owner_reg);
        start_use    = new_owner ? entry_count_reg[ENT_AW-1:0] : start_reg;
        len_use      = (new_owner ? ENT_CW'(0) : len_reg) + ENT_CW'(1);

        hi_tmp = (owner_a > highest_reg) ? owner_a : highest_reg;
        hi_tmp = (nb_a > hi_tmp) ? nb_a : hi_tmp;

        node_we    = take;
        node_waddr = owner_a;
        node_wdata = {HUE_NONE, start_use, len_use};
        list_we    = take;
        list_waddr = entry_count_reg[ENT_AW-1:0];
        list_wdata = nb_a;

        entry_count_next = entry_count_reg;
        owner_seen_next  = owner_seen_reg;
        prev_owner_next  = prev_owner_reg;
        error_next       = error_reg;
        highest_next     = highest_reg;
        start_next       = start_reg;
        len_next         = len_reg;

        priority if (graph_clear)
        begin
            entry_count_next = '0;
            owner_seen_next  = 1'b0;
            prev_owner_next  = '0;
            error_next       = 1'b0;
            highest_next     = '0;
            start_next       = '0;
            len_next         = '0;
        end
        else if (take)
        begin
            entry_count_next = entry_count_reg + ENT_CW'(1);
            owner_seen_next  = 1'b1;
            prev_owner_next  = owner_node;
            highest_next     = hi_tmp;
            start_next       = start_use;
            len_next         = len_use;
        end
        else if (in_accept && is_entry)
        begin
            error_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            owner_seen_reg  <= 1'b0;
            prev_owner_reg  <= '0;
            error_reg       <= 1'b0;
            highest_reg     <= '0;
            start_reg       <= '0;
            len_reg         <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            owner_seen_reg  <= owner_seen_next;
            prev_owner_reg  <= prev_owner_next;
            error_reg       <= error_next;
            highest_reg     <= highest_next;
            start_reg       <= start_next;
            len_reg         <= len_next;
        end
    end

    assign flags.error       = error_reg;
    assign flags.has_entries = (entry_count_reg != '0);
    assign highest           = highest_reg;

endmodule

`default_nettype wire

[rtl/core/bgc_walker.sv]
// bgc_walker: sequencer for the depth-first two-coloring walk and the node memory clear.
// Depends on bgc_pkg; drives the ports of the node, neighbor and stack memories.
`default_nettype none

module bgc_walker
    import bgc_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_ENTRIES = 4096,
    localparam int NODE_AW = $clog2(MAX_NODES),
    localparam int NODE_CW = $clog2(MAX_NODES + 1),
    localparam int ENT_AW  = $clog2(MAX_ENTRIES),
    localparam int ENT_CW  = $clog2(MAX_ENTRIES + 1),
    localparam int N_W     = (NODE_CW > CFG_W) ? NODE_CW : CFG_W,
    localparam int NODE_DW = HUE_W + ENT_AW + ENT_CW
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               last_accept,
    input  wire logic [N_W-1:0]     active_nodes,
    input  load_flags_t             flags,
    input  wire logic [NODE_AW-1:0] highest,
    input  wire logic               out_free,
    // loader requests for the node memory
    input  wire logic               ld_node_we,
    input  wire logic [NODE_AW-1:0] ld_node_waddr,
    input  wire logic [NODE_DW-1:0] ld_node_wdata,
    // node memory
    output logic                    node_we,
    output logic      [NODE_AW-1:0] node_waddr,
    output logic      [NODE_DW-1:0] node_wdata,
    output logic                    node_re,
    output logic      [NODE_AW-1:0] node_raddr,
    input  wire logic [NODE_DW-1:0] node_rdata,
    // neighbor store read
    output logic                    list_re,
    output logic      [ENT_AW-1:0]  list_raddr,
    input  wire logic [NODE_AW-1:0] list_rdata,
    // walk stack
    output logic                    stk_we,
    output logic      [NODE_AW-1:0] stk_waddr,
    output logic      [NODE_AW-1:0] stk_wdata,
    output logic                    stk_re,
    output logic      [NODE_AW-1:0] stk_raddr,
    input  wire logic [NODE_AW-1:0] stk_rdata,
    // control toward the ports
    output logic                    in_ready,
    output logic                    res_valid,
    output result_t                 res,
    output logic                    graph_clear
);

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b00000000001,
        ST_LOAD     = 11'b00000000010,
        ST_DECIDE   = 11'b00000000100,
        ST_SEED_RD  = 11'b00000001000,
        ST_SEED_CHK = 11'b00000010000,
        ST_NBR_RD   = 11'b00000100000,
        ST_NBR_NODE = 11'b00001000000,
        ST_NBR_CHK  = 11'b00010000000,
        ST_POP      = 11'b00100000000,
        ST_CUR      = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [NODE_AW-1:0] seed_reg, seed_next;
    logic [ENT_CW-1:0]  pos_reg, pos_next;
    logic [ENT_CW-1:0]  end_reg, end_next;
    hue_t               hue_reg, hue_next;
    logic [NODE_AW-1:0] nb_reg, nb_next;
    logic [NODE_CW-1:0] sp_reg, sp_next;
    logic [NODE_AW-1:0] clr_reg, clr_next;
    logic [NODE_AW-1:0] clr_last_reg, clr_last_next;
    result_t            res_reg, res_next;

    hue_t               rd_hue;
    logic [ENT_AW-1:0]  rd_start;
    logic [ENT_CW-1:0]  rd_len;
    logic [NODE_CW-1:0] sp_dec;
    logic               seed_adv;

    // Fields of the node word read back
    assign rd_hue   = hue_t'(node_rdata[NODE_DW-1 -: HUE_W]);
    assign rd_start = node_rdata[ENT_CW +: ENT_AW];
    assign rd_len   = node_rdata[ENT_CW-1:0];
    assign sp_dec   = sp_reg - NODE_CW'(1);

    // Walk sequencer
    always_comb
    begin
        state_next    = state_reg;
        seed_next     = seed_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        hue_next      = hue_reg;
        nb_next       = nb_reg;
        sp_next       = sp_reg;
        clr_next      = clr_reg;
        clr_last_next = clr_last_reg;
        res_next      = res_reg;
        seed_adv      = 1'b0;

        node_we    = 1'b0;
        node_waddr = ld_node_waddr;
        node_wdata = ld_node_wdata;
        node_re    = 1'b0;
        node_raddr = seed_reg;
        list_re    = 1'b0;
        list_raddr = pos_reg[ENT_AW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[NODE_AW-1:0];
        stk_wdata  = nb_reg;
        stk_re     = 1'b0;
        stk_raddr  = sp_dec[NODE_AW-1:0];
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        graph_clear = 1'b0;

        unique case (state_reg)
            // Reset every color and list length of the touched range
            ST_CLEAR:
            begin
                node_we    = 1'b1;
                node_waddr = clr_reg;
                node_wdata = {HUE_NONE, ENT_AW'(0), ENT_CW'(0)};
                if (clr_reg == clr_last_reg)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    clr_next = clr_reg + NODE_AW'(1);
                end
            end

            // Entries stream in; the loader owns the write port
            ST_LOAD:
            begin
                in_ready   = 1'b1;
                node_we    = ld_node_we;
                node_waddr = ld_node_waddr;
                node_wdata = ld_node_wdata;
                if (last_accept)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                seed_next = '0;
                sp_next   = '0;
                priority if (flags.error ||
                             (flags.has_entries && (N_W'(highest) >= active_nodes)))
                begin
                    res_next   = '{input_error: 1'b1, bipartite: 1'b0};
                    state_next = ST_DONE;
                end
                else if (!flags.has_entries)
                begin
                    res_next   = '{input_error: 1'b0, bipartite: 1'b1};
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SEED_RD;
                end
            end

            ST_SEED_RD:
            begin
                node_re    = 1'b1;
                node_raddr = seed_reg;
                state_next = ST_SEED_CHK;
            end

            // Uncolored seed gets color zero and becomes the current node
            ST_SEED_CHK:
            begin
                if (rd_hue != HUE_NONE)
                begin
                    seed_adv = 1'b1;
                end
                else
                begin
                    node_we    = 1'b1;
                    node_waddr = seed_reg;
                    node_wdata = {HUE_ZERO, rd_start, rd_len};
                    hue_next   = HUE_ZERO;
                    pos_next   = ENT_CW'(rd_start);
                    end_next   = ENT_CW'(rd_start) + rd_len;
                    state_next = ST_NBR_RD;
                end
            end

            // Next neighbor of the current node, or pop the stack
            ST_NBR_RD:
            begin
                if (pos_reg == end_reg)
                begin
                    if (sp_reg == '0)
                    begin
                        seed_adv = 1'b1;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        sp_next    = sp_dec;
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    list_re    = 1'b1;
                    state_next = ST_NBR_NODE;
                end
            end

            ST_NBR_NODE:
            begin
                node_re    = 1'b1;
                node_raddr = list_rdata;
                nb_next    = list_rdata;
                state_next = ST_NBR_CHK;
            end

            // Color and push an uncolored neighbor; same color is a conflict
            ST_NBR_CHK:
            begin
                priority if (rd_hue == HUE_NONE)
                begin
                    node_we    = 1'b1;
                    node_waddr = nb_reg;
                    node_wdata = {hue_flip(hue_reg), rd_start, rd_len};
                    if (sp_reg != NODE_CW'(MAX_NODES))
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + NODE_CW'(1);
                    end
                    pos_next   = pos_reg + ENT_CW'(1);
                    state_next = ST_NBR_RD;
                end
                else if (rd_hue == hue_reg)
                begin
                    res_next   = '{input_error: 1'b0, bipartite: 1'b0};
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next   = pos_reg + ENT_CW'(1);
                    state_next = ST_NBR_RD;
                end
            end

            ST_POP:
            begin
                node_re    = 1'b1;
                node_raddr = stk_rdata;
                state_next = ST_CUR;
            end

            ST_CUR:
            begin
                hue_next   = rd_hue;
                pos_next   = ENT_CW'(rd_start);
                end_next   = ENT_CW'(rd_start) + rd_len;
                state_next = ST_NBR_RD;
            end

            // Hand the result over, then clear what this graph touched
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid     = 1'b1;
                    graph_clear   = 1'b1;
                    clr_next      = '0;
                    clr_last_next = highest;
                    state_next    = flags.has_entries ? ST_CLEAR : ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        // Move to the next seed or finish with a two-colorable graph
        if (seed_adv)
        begin
            if (seed_reg == highest)
            begin
                res_next   = '{input_error: 1'b0, bipartite: 1'b1};
                state_next = ST_DONE;
            end
            else
            begin
                seed_next  = seed_reg + NODE_AW'(1);
                state_next = ST_SEED_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            seed_reg     <= '0;
            sp_reg       <= '0;
            clr_reg      <= '0;
            clr_last_reg <= NODE_AW'(MAX_NODES - 1);
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            seed_reg     <= seed_next;
            sp_reg       <= sp_next;
            clr_reg      <= clr_next;
            clr_last_reg <= clr_last_next;
            res_reg      <= res_next;
        end
    end

    // Walk payload registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        end_reg <= end_next;
        hue_reg <= hue_next;
        nb_reg  <= nb_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[rtl/core/bgc_checker.sv]
// bgc_checker: port-level assertions for graph_bipartite_check_top, with its bind.
// Depends on bgc_pkg and the top-level port list.
`default_nettype none

module bgc_checker
    import bgc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 s_axis_tlast,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An input error never reports a bipartite graph
    a_err_not_bip: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
        else $error("input error reported with bipartite set");

    // The check starts after the last request, so input stops right away
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after last request");

    // A request that is not last produces no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=>
            !m_axis_tvalid)
        else $error("result without a last request");

endmodule

bind graph_bipartite_check_top bgc_checker u_bgc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
